>>> hw/rtl/wmcc_pkg.sv
// Package for the windowed minimum-cost cover block.
// Holds transaction payload types, controller/datapath link types and constants.
// No dependencies.
package wmcc_pkg;

  localparam int unsigned MaxSpanDefault     = 255;
  localparam int unsigned WindowDepthDefault = 512;

  localparam int unsigned SpanW     = 8;
  localparam int unsigned CostW     = 16;
  localparam int unsigned BestW     = 32;
  localparam logic [SpanW-1:0] SpanReset = SpanW'(1);
  localparam logic [BestW-1:0] BestSat   = '1;

  typedef struct packed {
    logic [CostW-1:0] cost;
    logic             last;
  } in_t;

  typedef struct packed {
    logic [BestW-1:0] best_here;
    logic [BestW-1:0] answer;
    logic             done_res;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_CALC
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic init;
    logic rd_issue;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/windowed_min_cost_cover_dp.sv
// Steps: accept, scan of min(2k+1, positions so far) ring entries through the single read port,
// drain of the read pipe, and commit once the result register is free; only then is the next one accepted.
// The result register frees the input side while a result waits.
// Reset: asynchronous, active low; span returns to 1, position and ring pointer to zero.
// Ring contents are not cleared. Depends on wmcc_pkg, wmcc_ctrl, wmcc_dp.
module windowed_min_cost_cover_dp #(
  parameter int unsigned MAX_SPAN     = wmcc_pkg::MaxSpanDefault,
  parameter int unsigned WINDOW_DEPTH = wmcc_pkg::WindowDepthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [wmcc_pkg::SpanW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  wmcc_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output wmcc_pkg::out_t             out_data_o
);
  import wmcc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wmcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wmcc_dp #(
    .MAX_SPAN     (MAX_SPAN),
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

>>> hw/rtl/wmcc_dp.sv
// Datapath: span register, ring store of recent best values, window scan and result register.
// Depends on wmcc_pkg; driven by wmcc_ctrl through cmd_t, reports through sts_t.
module wmcc_dp #(
  parameter int unsigned MAX_SPAN     = wmcc_pkg::MaxSpanDefault,
  parameter int unsigned WINDOW_DEPTH = wmcc_pkg::WindowDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wmcc_pkg::SpanW-1:0]    cfg_wdata_i,
  input  wmcc_pkg::in_t                 in_data_i,
  input  wmcc_pkg::cmd_t                cmd_i,
  output wmcc_pkg::sts_t                sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output wmcc_pkg::out_t                out_data_o
);
  import wmcc_pkg::*;

  localparam int unsigned AW      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned PosCap  = 2 * MAX_SPAN + 2;
  localparam int unsigned PW      = $clog2(PosCap + 1);
  localparam int unsigned CW      = (PW > SpanW + 1) ? PW : SpanW + 1;
  localparam int unsigned KMax    = (MAX_SPAN < (WINDOW_DEPTH - 1) / 2) ?
                                    MAX_SPAN : (WINDOW_DEPTH - 1) / 2;
  localparam logic [AW-1:0] LastSlot = AW'(WINDOW_DEPTH - 1);

  logic [BestW-1:0] mem_q [WINDOW_DEPTH];

  logic [SpanW-1:0] span_q;
  logic [PW-1:0]    pos_q, pos_d;
  logic [AW-1:0]    wp_q, wp_d;
  logic [AW-1:0]    rp_q, rp_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    lim1_q, lim1_d;
  logic [CW-1:0]    lim2_q, lim2_d;
  logic [BestW-1:0] mn_q, mn_d;
  logic [BestW-1:0] mk_q, mk_d;
  logic [CostW-1:0] cost_q;
  logic             last_q;
  logic             rd_vld_q;
  logic             rd_in2_q;
  logic [BestW-1:0] rd_data_q;
  logic             out_valid_q;
  out_t             out_q;

  logic [CW-1:0]    k_cw;
  logic [CW-1:0]    pos_cw;
  logic [CW-1:0]    full1;
  logic [BestW:0]   sum;
  logic [BestW-1:0] best;
  logic [BestW-1:0] ans;

  // effective reach and scan limits
  always_comb begin
    k_cw = CW'(span_q);
    if (k_cw > CW'(KMax)) begin
      k_cw = CW'(KMax);
    end
    pos_cw = CW'(pos_q);
    full1  = (k_cw << 1) + CW'(1);
    lim1_d = (full1 < pos_cw) ? full1 : pos_cw;
    lim2_d = (k_cw < pos_cw) ? k_cw : pos_cw;
  end

  always_comb begin
    sum  = {1'b0, mn_q} + (BestW + 1)'(cost_q);
    best = sum[BestW] ? BestSat : sum[BestW-1:0];
    ans  = (mk_q < best) ? mk_q : best;
  end

  always_comb begin
    cnt_d = cnt_q;
    rp_d  = rp_q;
    mn_d  = mn_q;
    mk_d  = mk_q;
    if (cmd_i.init) begin
      cnt_d = '0;
      rp_d  = (wp_q == '0) ? LastSlot : wp_q - AW'(1);
      mn_d  = (pos_cw <= k_cw) ? '0 : BestSat;
      mk_d  = BestSat;
    end else begin
      if (cmd_i.rd_issue) begin
        cnt_d = cnt_q + CW'(1);
        rp_d  = (rp_q == '0) ? LastSlot : rp_q - AW'(1);
      end
      if (rd_vld_q) begin
        if (rd_data_q < mn_q) begin
          mn_d = rd_data_q;
        end
        if (rd_in2_q && (rd_data_q < mk_q)) begin
          mk_d = rd_data_q;
        end
      end
    end
  end

  always_comb begin
    pos_d = pos_q;
    wp_d  = wp_q;
    if (cmd_i.commit) begin
      if (last_q) begin
        pos_d = '0;
        wp_d  = '0;
      end else begin
        if (pos_q < PW'(PosCap)) begin
          pos_d = pos_q + PW'(1);
        end
        wp_d = (wp_q == LastSlot) ? '0 : wp_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q      <= SpanReset;
      pos_q       <= '0;
      wp_q        <= '0;
      rp_q        <= '0;
      cnt_q       <= '0;
      lim1_q      <= '0;
      lim2_q      <= '0;
      rd_vld_q    <= 1'b0;
      rd_in2_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        span_q <= cfg_wdata_i;
      end
      pos_q    <= pos_d;
      wp_q     <= wp_d;
      rp_q     <= rp_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= cmd_i.rd_issue;
      rd_in2_q <= cnt_q < lim2_q;
      if (cmd_i.init) begin
        lim1_q <= lim1_d;
        lim2_q <= lim2_d;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mn_q <= mn_d;
    mk_q <= mk_d;
    if (cmd_i.init) begin
      cost_q <= in_data_i.cost;
      last_q <= in_data_i.last;
    end
    if (cmd_i.commit) begin
      out_q.best_here <= best;
      out_q.answer    <= ans;
      out_q.done_res  <= last_q;
    end
  end

  // ring store
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      mem_q[wp_q] <= best;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem_q[rp_q];
    end
  end

  assign sts_o.scan_done = (cnt_q == lim1_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

>>> hw/rtl/wmcc_ctrl.sv
// Controller state machine: accept, window scan, drain of the read pipe, commit.
// Depends on wmcc_pkg; drives wmcc_dp through cmd_t.
module wmcc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  wmcc_pkg::sts_t sts_i,
  output wmcc_pkg::cmd_t cmd_o
);
  import wmcc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.init = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.rd_issue = 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_CALC;
      end
      ST_CALC: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
